// ----- src/deq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEQ_DEPTH      = 8;
	localparam int DEQ_WORD_WIDTH = 32;

	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] data;
	} deq_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] front_word;
		logic signed [31:0] rear_word;
		logic               is_empty;
		logic               is_full;
		logic [3:0]         fill_count;
	} deq_out_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic rd;
	} deq_ctl_t;

endpackage
`default_nettype wire

// ----- src/deq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept a word, update the store, read the ends, strobe result.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output deq_ctl_t  ctl,
	output logic      busy,
	output logic      done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q == S_EXEC) || (state_q == S_READ);
	assign done   = (state_q == S_DONE);
	assign accept = start && !busy;

	assign ctl.load = accept;
	assign ctl.exec = (state_q == S_EXEC);
	assign ctl.rd   = (state_q == S_READ);

	always_comb begin
		case (state_q)
			S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
			S_EXEC:  state_d = S_READ;
			S_READ:  state_d = S_DONE;
			S_DONE:  state_d = accept ? S_EXEC : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/deq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_datapath
// Slot store, head and tail pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module deq_datapath
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEQ_DEPTH,
	parameter int WORD_WIDTH = DEQ_WORD_WIDTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire deq_ctl_t ctl,
	input  wire deq_in_t  cmd,
	output deq_out_t      result
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WORD_WIDTH-1:0] mem_q [DEPTH];

	logic [1:0]                   op_q;
	logic [WORD_WIDTH-1:0]        data_q;
	logic [PW-1:0]                head_q;
	logic [PW-1:0]                tail_q;
	logic [CW-1:0]                count_q;
	logic [1:0]                   status_q;
	logic signed [WORD_WIDTH-1:0] rd_front_q;
	logic signed [WORD_WIDTH-1:0] rd_rear_q;

	logic [PW-1:0] head_d;
	logic [PW-1:0] tail_d;
	logic [CW-1:0] count_d;
	logic [1:0]    status_d;
	logic          we;
	logic [PW-1:0] waddr;
	logic [PW-1:0] head_inc;
	logic [PW-1:0] head_dec;
	logic [PW-1:0] tail_inc;
	logic [PW-1:0] tail_dec;
	logic          empty;

	assign empty    = (count_q == '0);
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = ST_OK;
		we       = 1'b0;
		waddr    = '0;
		if (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_REAR) begin
			if (count_q == FULL_CNT) begin
				status_d = ST_OVERFLOW;
			end else begin
				we      = 1'b1;
				count_d = count_q + 1'b1;
				if (empty) begin
					head_d = '0;
					tail_d = '0;
					waddr  = '0;
				end else if (op_q == OP_PUSH_FRONT) begin
					head_d = head_dec;
					waddr  = head_dec;
				end else begin
					tail_d = tail_inc;
					waddr  = tail_inc;
				end
			end
		end else begin
			if (empty) begin
				status_d = ST_UNDERFLOW;
			end else begin
				count_d = count_q - 1'b1;
				if (head_q == tail_q) begin
					head_d = '0;
					tail_d = '0;
				end else if (op_q == OP_POP_FRONT) begin
					head_d = head_inc;
				end else begin
					tail_d = tail_dec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= ST_OK;
		end else if (ctl.exec) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q   <= cmd.op;
			data_q <= WORD_WIDTH'(cmd.data);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && we) begin
			mem_q[waddr] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_front_q <= mem_q[head_q];
			rd_rear_q  <= mem_q[tail_q];
		end
	end

	assign result.status     = status_q;
	assign result.front_word = empty ? '1 : 32'(rd_front_q);
	assign result.rear_word  = empty ? '1 : 32'(rd_rear_q);
	assign result.is_empty   = empty;
	assign result.is_full    = (count_q == FULL_CNT);
	assign result.fill_count = 4'(count_q);

endmodule
`default_nettype wire

// ----- src/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Fixed-depth circular double-ended queue with status per operation.
// Each accepted word passes the EXEC state, then the READ state, then the result strobe.
// A new word is not taken while busy; a new word is taken in the strobe cycle.
// EXEC writes the slot, and READ registers the words at both ends of the queue.
// Results cannot be stalled; each is shown for exactly one cycle.
// Reset clears pointers, fill count and sequencer; slot contents stay undefined.
// ----------------------------------------------------------------------------
module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEQ_DEPTH,
	parameter int WORD_WIDTH = DEQ_WORD_WIDTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire deq_in_t cmd,
	output logic         busy,
	output logic         done,
	output deq_out_t     result
);

	deq_ctl_t ctl;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	deq_datapath #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.result (result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing three cycles after accept");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_empty && result.is_full))
		else $error("queue reported empty and full");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |->
		(result.fill_count == 4'd0 && result.front_word == '1 && result.rear_word == '1))
		else $error("empty queue result inconsistent");

endmodule
`default_nettype wire
